// ===== rtl/core/sscond_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sscond_pkg;

    // defaults for the top level parameters
    localparam int FRAC_BITS_DEF  = 24;
    localparam int ATAN_STEPS_DEF = 24;

    // field widths
    localparam int FIELD_W    = 32;
    localparam int COUPLING_W = 31;
    localparam int PROD_W     = 2 * COUPLING_W;

    // quotient bits of the static conductance divider
    localparam int SQ_BITS = 32;

    // cordic step angles atan(2^-i) in q2.30
    localparam logic [31:0] ATAN_Q30 [32] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
        32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
        32'h00000001, 32'h00000000
    };

endpackage

`default_nettype wire

// ===== rtl/core/single_site_conductance_eval_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// single-site junction conductance evaluator. one transaction is one sample of a
// one-level junction (fermi energy, bias, site energy, two couplings, asymmetry,
// all fixed point with FRAC_BITS fraction bits) and gives exactly one result:
// static conductance from a difference of two cordic arctangents, differential
// conductance from two lorentzian transmissions, both saturated to 32 bits, plus
// zero-bias and zero-width flags. the block is a straight pipeline with no
// feedback, so it takes a new transaction every clock; busy is high only during
// reset and until the first clock edge after it. the static path holds the
// ATAN_STEPS cordic stages and the 32-stage restoring divider, plus the input,
// setup, product, seed and output stages, with the shorter lorentzian path
// delayed to match. the receiver cannot stall, and nothing in the block waits
// on it.
module single_site_conductance_eval_top
    import sscond_pkg::*;
#(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int ATAN_STEPS = ATAN_STEPS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [FIELD_W-1:0]    i_fermi_energy,
    input  logic signed [FIELD_W-1:0]    i_bias_voltage,
    input  logic signed [FIELD_W-1:0]    i_site_energy,
    input  logic        [COUPLING_W-1:0] i_left_coupling,
    input  logic        [COUPLING_W-1:0] i_right_coupling,
    input  logic signed [FIELD_W-1:0]    i_asymmetry,
    output logic                         o_valid,
    output logic signed [FIELD_W-1:0]    o_static_conductance,
    output logic signed [FIELD_W-1:0]    o_diff_conductance,
    output logic                         o_zero_bias_flag,
    output logic                         o_zero_width_flag
);

    // detuning x = ef - eps +- v/2 - a*v, |x| < 2^(XW-1) for any FRAC_BITS in range
    localparam int XW  = 66 - FRAC_BITS;
    // 2|x| split in two halves for the square
    localparam int HW  = (XW + 1) / 2;
    localparam int UW  = XW - HW;
    // lorentzian denominator 4x^2 + s^2 and its partial remainder
    localparam int DW  = 2 * XW + 1;
    localparam int RW  = DW + 1;
    // lorentzian transmission 0 .. 2^F
    localparam int QL  = FRAC_BITS + 1;
    // weighted transmission products
    localparam int PW  = 33 + QL + 1;
    // cordic datapath and angle accumulator
    localparam int CW  = XW + 3;
    localparam int ZW  = FRAC_BITS + 3;
    localparam int DAW = ZW + 1;
    localparam int MW  = FRAC_BITS + 2;
    // static numerator 2*gl*gr*|dang|
    localparam int NW  = FRAC_BITS + 66;
    localparam int OW  = 64 + SQ_BITS;
    // diff path is shorter than the static path by this many stages
    localparam int DLY = ATAN_STEPS + 31 - FRAC_BITS;
    localparam int LAT = ATAN_STEPS + 39;

    localparam logic signed [32:0] HALF = 33'(64'(1) << (FRAC_BITS - 1));
    localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_NEG = 32'h8000_0000;

    typedef struct packed {
        logic                  vld;
        logic                  zb;
        logic                  zw;
        logic signed [31:0]    v;
        logic [31:0]           s;
        logic [PROD_W-1:0]     glgr;
    } t_side;

    typedef struct packed {
        logic vld;
        logic zb;
        logic zw;
        logic neg;
        logic ovf;
    } t_sflag;

    //------------------------------------------------------------------
    // accept side: no back pressure once out of reset
    //------------------------------------------------------------------
    logic r_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready <= 1'b0;
        end else begin
            r_ready <= 1'b1;
        end
    end

    assign busy = ~r_ready;

    //------------------------------------------------------------------
    // stage 0: input register
    //------------------------------------------------------------------
    logic                         r0_vld;
    logic signed [FIELD_W-1:0]    r0_ef, r0_v, r0_eps, r0_a;
    logic        [COUPLING_W-1:0] r0_gl, r0_gr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
        end else begin
            r0_vld <= start && !busy;
        end
        r0_ef  <= i_fermi_energy;
        r0_v   <= i_bias_voltage;
        r0_eps <= i_site_energy;
        r0_gl  <= i_left_coupling;
        r0_gr  <= i_right_coupling;
        r0_a   <= i_asymmetry;
    end

    //------------------------------------------------------------------
    // stage 1: a*v, gl*gr, coupling sum, ef - eps
    //------------------------------------------------------------------
    logic signed [63:0]       n1_av;
    logic        [PROD_W-1:0] n1_glgr;
    logic        [31:0]       n1_s;
    logic signed [32:0]       n1_d;

    assign n1_av   = 64'(r0_a) * 64'(r0_v);
    assign n1_glgr = PROD_W'(r0_gl) * PROD_W'(r0_gr);
    assign n1_s    = 32'(r0_gl) + 32'(r0_gr);
    assign n1_d    = 33'(r0_ef) - 33'(r0_eps);

    logic                     r1_vld, r1_zb, r1_zw;
    logic signed [63:0]       r1_av;
    logic        [PROD_W-1:0] r1_glgr;
    logic        [31:0]       r1_s;
    logic signed [32:0]       r1_d;
    logic signed [31:0]       r1_v, r1_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= r0_vld;
        end
        r1_zb   <= (r0_v == '0);
        r1_zw   <= (n1_s == '0);
        r1_av   <= n1_av;
        r1_glgr <= n1_glgr;
        r1_s    <= n1_s;
        r1_d    <= n1_d;
        r1_v    <= r0_v;
        r1_a    <= r0_a;
    end

    //------------------------------------------------------------------
    // stage 2: detunings x1, x2 at the two bias edges, s^2
    //------------------------------------------------------------------
    logic signed [XW-1:0] n2_av, n2_d, n2_hv;

    assign n2_av = XW'(r1_av >>> FRAC_BITS);
    assign n2_d  = XW'(r1_d);
    assign n2_hv = XW'(r1_v >>> 1);

    logic                     r2_vld, r2_zb, r2_zw;
    logic signed [XW-1:0]     r2_x [2];
    logic        [63:0]       r2_s2;
    logic        [31:0]       r2_s;
    logic        [PROD_W-1:0] r2_glgr;
    logic signed [31:0]       r2_v, r2_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
        r2_zb   <= r1_zb;
        r2_zw   <= r1_zw;
        r2_x[0] <= n2_d + n2_hv - n2_av;
        r2_x[1] <= n2_d - n2_hv - n2_av;
        r2_s2   <= 64'(r1_s) * 64'(r1_s);
        r2_s    <= r1_s;
        r2_glgr <= r1_glgr;
        r2_v    <= r1_v;
        r2_a    <= r1_a;
    end

    //------------------------------------------------------------------
    // lorentzian path: T(x) = 4*gl*gr*2^F / (4x^2 + s^2)
    //------------------------------------------------------------------
    // L1: partial products of (2|x|)^2
    logic [2*UW-1:0]    rl1_hh [2];
    logic [XW-1:0]      rl1_hl [2];
    logic [2*HW-1:0]    rl1_ll [2];
    logic [63:0]        rl1_s2;
    logic [PROD_W-1:0]  rl1_glgr;
    logic signed [31:0] rl1_a;

    // L2: full denominator, remainder starts at 4*gl*gr
    logic [DW-1:0]      rl2_den [2];
    logic [63:0]        rl2_rem;
    logic signed [31:0] rl2_a;

    for (genvar l = 0; l < 2; l++) begin : g_lsq
        logic signed [XW-1:0] ax;
        logic        [XW-1:0] t;
        logic        [UW-1:0] th;
        logic        [HW-1:0] tl;

        assign ax = r2_x[l][XW-1] ? -r2_x[l] : r2_x[l];
        assign t  = {ax[XW-2:0], 1'b0};
        assign th = t[XW-1:HW];
        assign tl = t[HW-1:0];

        always_ff @(posedge i_clk) begin
            rl1_hh[l]  <= (2*UW)'(th) * (2*UW)'(th);
            rl1_hl[l]  <= XW'(th) * XW'(tl);
            rl1_ll[l]  <= (2*HW)'(tl) * (2*HW)'(tl);
            rl2_den[l] <= (DW'(rl1_hh[l]) << (2 * HW)) + (DW'(rl1_hl[l]) << (HW + 1))
                        + DW'(rl1_ll[l]) + DW'(rl1_s2);
        end
    end

    always_ff @(posedge i_clk) begin
        rl1_s2   <= r2_s2;
        rl1_glgr <= r2_glgr;
        rl1_a    <= r2_a;
        rl2_rem  <= {rl1_glgr, 2'b00};
        rl2_a    <= rl1_a;
    end

    // restoring divider, one quotient bit per stage, msb (bit F) first
    logic [DW-1:0]      r_lrem [2][QL];
    logic [DW-1:0]      r_lden [2][QL];
    logic [QL-1:0]      r_lq   [2][QL];
    logic signed [31:0] r_la   [QL];

    for (genvar j = 0; j < QL; j++) begin : g_ldiv
        logic signed [31:0] a_in;

        if (j == 0) begin : g_first
            assign a_in = rl2_a;
        end else begin : g_next
            assign a_in = r_la[j-1];
        end

        always_ff @(posedge i_clk) begin
            r_la[j] <= a_in;
        end

        for (genvar l = 0; l < 2; l++) begin : g_lane
            logic [DW-1:0] rem_in, den_in;
            logic [QL-1:0] q_in;
            logic [RW-1:0] rr;
            logic          ge;

            if (j == 0) begin : g_first
                assign rem_in = DW'(rl2_rem);
                assign den_in = rl2_den[l];
                assign q_in   = '0;
                assign rr     = RW'(rem_in);
            end else begin : g_next
                assign rem_in = r_lrem[l][j-1];
                assign den_in = r_lden[l][j-1];
                assign q_in   = r_lq[l][j-1];
                assign rr     = RW'(rem_in) << 1;
            end

            assign ge = (rr >= RW'(den_in));

            always_ff @(posedge i_clk) begin
                r_lrem[l][j] <= DW'(ge ? rr - RW'(den_in) : rr);
                r_lden[l][j] <= den_in;
                r_lq[l][j]   <= {q_in[QL-2:0], ge};
            end
        end
    end

    // L3: weights (1/2 - a) and (1/2 + a)
    logic signed [32:0]   n_w1, n_w2;
    logic signed [PW-1:0] rl3_p1, rl3_p2;

    assign n_w1 = HALF - 33'(r_la[QL-1]);
    assign n_w2 = HALF + 33'(r_la[QL-1]);

    always_ff @(posedge i_clk) begin
        rl3_p1 <= PW'(n_w1) * PW'($signed({1'b0, r_lq[0][QL-1]}));
        rl3_p2 <= PW'(n_w2) * PW'($signed({1'b0, r_lq[1][QL-1]}));
    end

    // L4: sum, scale back, saturate
    logic signed [PW:0]   n_acc, n_acc_sh;
    logic                 n_acc_fit;
    logic signed [31:0]   rl4_diff;

    assign n_acc     = (PW+1)'(rl3_p1) + (PW+1)'(rl3_p2);
    assign n_acc_sh  = n_acc >>> FRAC_BITS;
    assign n_acc_fit = (&n_acc_sh[PW:31]) || !(|n_acc_sh[PW:31]);

    always_ff @(posedge i_clk) begin
        if (n_acc_fit) begin
            rl4_diff <= n_acc_sh[31:0];
        end else if (n_acc_sh[PW]) begin
            rl4_diff <= SAT_NEG;
        end else begin
            rl4_diff <= SAT_POS;
        end
    end

    // line up with the static path
    logic signed [31:0] r_ddly [DLY];

    for (genvar k = 0; k < DLY; k++) begin : g_ddly
        if (k == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                r_ddly[k] <= rl4_diff;
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                r_ddly[k] <= r_ddly[k-1];
            end
        end
    end

    //------------------------------------------------------------------
    // static path: two vectoring cordics from (s, 2x1) and (s, 2x2)
    //------------------------------------------------------------------
    logic signed [CW-1:0] r_cx [2][ATAN_STEPS];
    logic signed [CW-1:0] r_cy [2][ATAN_STEPS];
    logic signed [ZW-1:0] r_cz [2][ATAN_STEPS];
    t_side                r_cs [ATAN_STEPS];

    t_side n_side0;

    assign n_side0 = '{vld: r2_vld, zb: r2_zb, zw: r2_zw, v: r2_v, s: r2_s,
                       glgr: r2_glgr};

    for (genvar i = 0; i < ATAN_STEPS; i++) begin : g_cordic
        localparam logic signed [ZW-1:0] ANG = ZW'(ATAN_Q30[i] >> (30 - FRAC_BITS));

        t_side side_in;

        if (i == 0) begin : g_first
            assign side_in = n_side0;
        end else begin : g_next
            assign side_in = r_cs[i-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cs[i] <= '0;
            end else begin
                r_cs[i] <= side_in;
            end
        end

        for (genvar l = 0; l < 2; l++) begin : g_lane
            logic signed [CW-1:0] xi, yi, dx, dy;
            logic signed [ZW-1:0] zi;

            if (i == 0) begin : g_first
                assign xi = CW'(r2_s);
                assign yi = CW'(r2_x[l]) <<< 1;
                assign zi = '0;
            end else begin : g_next
                assign xi = r_cx[l][i-1];
                assign yi = r_cy[l][i-1];
                assign zi = r_cz[l][i-1];
            end

            assign dx = yi >>> i;
            assign dy = xi >>> i;

            always_ff @(posedge i_clk) begin
                if (!yi[CW-1]) begin
                    r_cx[l][i] <= xi + dx;
                    r_cy[l][i] <= yi - dy;
                    r_cz[l][i] <= zi + ANG;
                end else begin
                    r_cx[l][i] <= xi - dx;
                    r_cy[l][i] <= yi + dy;
                    r_cz[l][i] <= zi - ANG;
                end
            end
        end
    end

    // C1: angle difference, signs, |v|
    t_side                n_cl;
    logic signed [DAW-1:0] n_dang;

    assign n_cl   = r_cs[ATAN_STEPS-1];
    assign n_dang = DAW'(r_cz[0][ATAN_STEPS-1]) - DAW'(r_cz[1][ATAN_STEPS-1]);

    logic                r_c1_vld, r_c1_zb, r_c1_zw, r_c1_neg;
    logic [MW-1:0]       r_c1_mag;
    logic [31:0]         r_c1_vmag, r_c1_s;
    logic [PROD_W-1:0]   r_c1_glgr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1_vld <= 1'b0;
        end else begin
            r_c1_vld <= n_cl.vld;
        end
        r_c1_zb   <= n_cl.zb;
        r_c1_zw   <= n_cl.zw;
        r_c1_neg  <= n_dang[DAW-1] ^ n_cl.v[31];
        r_c1_mag  <= MW'(n_dang[DAW-1] ? -n_dang : n_dang);
        r_c1_vmag <= n_cl.v[31] ? 32'(-n_cl.v) : 32'(n_cl.v);
        r_c1_s    <= n_cl.s;
        r_c1_glgr <= n_cl.glgr;
    end

    // C2: gl*gr*|dang| in two halves, |v|*s
    t_sflag                   r_c2_f;
    logic [COUPLING_W+MW-1:0] r_c2_pa, r_c2_pb;
    logic [63:0]              r_c2_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c2_f <= '0;
        end else begin
            r_c2_f <= '{vld: r_c1_vld, zb: r_c1_zb, zw: r_c1_zw, neg: r_c1_neg, ovf: 1'b0};
        end
        r_c2_pa  <= (COUPLING_W+MW)'(r_c1_glgr[COUPLING_W-1:0]) * (COUPLING_W+MW)'(r_c1_mag);
        r_c2_pb  <= (COUPLING_W+MW)'(r_c1_glgr[PROD_W-1:COUPLING_W])
                  * (COUPLING_W+MW)'(r_c1_mag);
        r_c2_den <= 64'(r_c1_vmag) * 64'(r_c1_s);
    end

    // C3: numerator 2*gl*gr*|dang|
    t_sflag        r_c3_f;
    logic [NW-1:0] r_c3_num;
    logic [63:0]   r_c3_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c3_f <= '0;
        end else begin
            r_c3_f <= r_c2_f;
        end
        r_c3_num <= (NW'(r_c2_pb) << (COUPLING_W + 1)) + (NW'(r_c2_pa) << 1);
        r_c3_den <= r_c2_den;
    end

    // C4: quotient of 2^32 or more saturates either way; else seed the divider
    logic n_ovf;

    assign n_ovf = (OW'(r_c3_num) >= {r_c3_den, SQ_BITS'(0)});

    t_sflag              r_sf   [SQ_BITS+1];
    logic [63:0]         r_srem [SQ_BITS+1];
    logic [63:0]         r_sden [SQ_BITS+1];
    logic [SQ_BITS-1:0]  r_slo  [SQ_BITS+1];
    logic [SQ_BITS-1:0]  r_sq   [SQ_BITS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sf[0] <= '0;
        end else begin
            r_sf[0] <= '{vld: r_c3_f.vld, zb: r_c3_f.zb, zw: r_c3_f.zw,
                         neg: r_c3_f.neg, ovf: n_ovf};
        end
        r_srem[0] <= 64'(r_c3_num >> SQ_BITS);
        r_sden[0] <= r_c3_den;
        r_slo[0]  <= r_c3_num[SQ_BITS-1:0];
        r_sq[0]   <= '0;
    end

    // restoring divider for the 32 low quotient bits
    for (genvar j = 1; j <= SQ_BITS; j++) begin : g_sdiv
        logic [64:0] rr;
        logic        ge;

        assign rr = {r_srem[j-1], r_slo[j-1][SQ_BITS-1]};
        assign ge = (rr >= {1'b0, r_sden[j-1]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sf[j] <= '0;
            end else begin
                r_sf[j] <= r_sf[j-1];
            end
            r_srem[j] <= 64'(ge ? rr - {1'b0, r_sden[j-1]} : rr);
            r_sden[j] <= r_sden[j-1];
            r_slo[j]  <= r_slo[j-1] << 1;
            r_sq[j]   <= {r_sq[j-1][SQ_BITS-2:0], ge};
        end
    end

    //------------------------------------------------------------------
    // output register: sign, saturation, special cases
    //------------------------------------------------------------------
    t_sflag              n_of;
    logic [SQ_BITS-1:0]  n_q;
    logic signed [31:0]  n_stat;

    assign n_of = r_sf[SQ_BITS];
    assign n_q  = r_sq[SQ_BITS];

    always_comb begin
        if (n_of.zw || n_of.zb) begin
            n_stat = '0;
        end else if (n_of.neg) begin
            n_stat = (n_of.ovf || n_q > SAT_NEG) ? SAT_NEG : 32'(-n_q);
        end else begin
            n_stat = (n_of.ovf || n_q[SQ_BITS-1]) ? SAT_POS : 32'(n_q);
        end
    end

    logic               r_out_vld, r_out_zb, r_out_zw;
    logic signed [31:0] r_out_stat, r_out_diff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= n_of.vld;
        end
        r_out_zb   <= n_of.zb;
        r_out_zw   <= n_of.zw;
        r_out_stat <= n_stat;
        r_out_diff <= n_of.zw ? '0 : r_ddly[DLY-1];
    end

    assign o_valid              = r_out_vld;
    assign o_static_conductance = r_out_stat;
    assign o_diff_conductance   = r_out_diff;
    assign o_zero_bias_flag     = r_out_zb;
    assign o_zero_width_flag    = r_out_zw;

    //------------------------------------------------------------------
    // assertions
    //------------------------------------------------------------------
    // every result comes from a transaction taken into the input register earlier
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r0_vld, LAT))
        else $error("result without a matching transaction");

    a_zero_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_zero_width_flag) |->
            (o_static_conductance == '0 && o_diff_conductance == '0))
        else $error("zero width result not cleared");

    a_zero_bias: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_zero_bias_flag) |-> (o_static_conductance == '0))
        else $error("zero bias static result not cleared");

    // the pipeline never pushes back once out of reset
    a_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> !busy)
        else $error("busy outside reset");

endmodule

`default_nettype wire
